FILE: design/max_heap_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max-heap priority queue
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// check a property on every rising edge outside reset
`define MHPQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising edge, reset included
`define MHPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and codes shared by the max-heap priority queue and its interfaces.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 8;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_LOAD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_DONE
   } state_type;

endpackage

FILE: design/mhpq_req_if.sv
// ----------------------------------------------------------------------------
// mhpq_req_if
// Request channel: insert a value or remove the maximum.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
   import mhpq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, req_type, value, input ready);
   modport sink   (input valid, req_type, value, output ready);

endinterface

FILE: design/mhpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mhpq_rsp_if
// Response channel: status, removed word, new top and entry count.
// ----------------------------------------------------------------------------
interface mhpq_rsp_if;
   import mhpq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [VALUE_W-1:0]  removed_value;
   logic signed [VALUE_W-1:0]  top_value;
   logic [COUNT_OUT_W-1:0]     entry_count;

   modport source (output valid, status, removed_value, top_value, entry_count,
                   input ready);
   modport sink   (input valid, status, removed_value, top_value, entry_count,
                   output ready);

endinterface

FILE: design/max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap over signed 32-bit words, held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//   channel   dir   word                                       handshake
//   req_ch    in    req_type, value                            valid/ready
//   rsp_ch    out   status, removed_value, top_value, count    valid/ready
//
// Flow: one request at a time, taken only in ST_IDLE. An insert climbs, a RAM
//   read (ST_UP_RD) then a compare/write (ST_UP_CMP) per level, to the root or
//   a parent that is not smaller; a remove loads the last entry (ST_DN_LOAD)
//   and descends, ST_DN_RD then ST_DN_CMP per level, to a leaf or a parent no
//   child beats. Full insert, empty remove and removal of the last entry go to
//   ST_DONE at once; the next request can be taken in the cycle after the load.
// Reset: clears the entry count and control; the RAM needs no clearing, as
//   only entries below the count are ever used.
// Stalls: a finished word waits in the response register while the next
//   request is taken; a second result stalls in ST_DONE until it drains.
//
`include "max_heap_priority_queue_macros.svh"

module max_heap_priority_queue #(
   parameter int CAPACITY = 128
) (
   input logic        clock,
   input logic        reset,
   mhpq_req_if.sink   req_ch,
   mhpq_rsp_if.source rsp_ch
);
   import mhpq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // heap RAM, level order: children of p at 2p+1 and 2p+2
   logic [VALUE_W-1:0] heap_mem [CAPACITY];
   logic [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]      rd_addr_a, rd_addr_b;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [VALUE_W-1:0]  hold_ff, hold_in;      // word being sifted
   logic [VALUE_W-1:0]  top_ff;                // mirror of the root entry
   logic [VALUE_W-1:0]  removed_ff, removed_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [VALUE_W-1:0]     rsp_removed_ff, rsp_top_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;

   logic          req_accept;
   logic          rsp_load;
   logic [AW-1:0] parent_idx;
   logic [AW+1:0] left_w, right_w, count_w;
   logic          left_ok, right_ok, take_right, child_wins, parent_loses;
   logic [AW-1:0] best_idx;
   logic [VALUE_W-1:0] best_val;

   // check terms
   logic          remove_on_empty, empty_flagged, full_status_out, queue_full;

   // ------------------------------------------------------------------
   // index arithmetic
   // ------------------------------------------------------------------
   assign parent_idx = (pos_ff - AW'(1)) >> 1;
   assign left_w     = (AW + 2)'({pos_ff, 1'b1});
   assign right_w    = left_w + (AW + 2)'(1);
   assign count_w    = (AW + 2)'(count_ff);
   assign left_ok    = left_w < count_w;
   assign right_ok   = right_w < count_w;

   // sift-down: larger child, left on ties; swap only if strictly larger
   assign take_right   = right_ok && ($signed(rd_b_ff) > $signed(rd_a_ff));
   assign best_val     = take_right ? rd_b_ff : rd_a_ff;
   assign best_idx     = take_right ? AW'(right_w) : AW'(left_w);
   assign child_wins   = $signed(best_val) > $signed(hold_ff);
   // sift-up: move only while parent strictly smaller
   assign parent_loses = $signed(hold_ff) > $signed(rd_a_ff);

   assign req_accept = req_ch.valid && req_ch.ready;

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.req_type == REQ_INSERT) begin
                  state_in = (count_ff == CW'(CAPACITY)) ? ST_DONE : ST_UP_RD;
               end else begin
                  state_in = (count_ff <= CW'(1)) ? ST_DONE : ST_DN_LOAD;
               end
            end
         end
         ST_UP_RD:   state_in = (pos_ff == '0) ? ST_DONE : ST_UP_CMP;
         ST_UP_CMP:  state_in = parent_loses ? ST_UP_RD : ST_DONE;
         ST_DN_LOAD: state_in = ST_DN_RD;
         ST_DN_RD:   state_in = left_ok ? ST_DN_CMP : ST_DONE;
         ST_DN_CMP:  state_in = child_wins ? ST_DN_RD : ST_DONE;
         ST_DONE:    state_in = rsp_load ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // RAM control and handshake outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_ch.ready = 1'b0;
      rsp_load     = 1'b0;
      rd_addr_a    = AW'(left_w);
      rd_addr_b    = AW'(right_w);
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = hold_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            rd_addr_a    = AW'(count_ff - CW'(1));   // last entry, for a remove
         end
         ST_UP_RD: begin
            rd_addr_a = parent_idx;
            wr_en     = (pos_ff == '0);
         end
         ST_UP_CMP: begin
            wr_en   = 1'b1;
            wr_data = parent_loses ? rd_a_ff : hold_ff;
         end
         ST_DN_RD: begin
            wr_en = !left_ok;
         end
         ST_DN_CMP: begin
            wr_en   = 1'b1;
            wr_data = child_wins ? best_val : hold_ff;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      count_in   = count_ff;
      pos_in     = pos_ff;
      hold_in    = hold_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               removed_in = '0;
               status_in  = STATUS_OK;
               if (req_ch.req_type == REQ_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     count_in = count_ff + CW'(1);
                     pos_in   = AW'(count_ff);
                     hold_in  = req_ch.value;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     count_in   = count_ff - CW'(1);
                     removed_in = top_ff;
                  end
               end
            end
         end
         ST_UP_CMP: begin
            if (parent_loses) begin
               pos_in = parent_idx;
            end
         end
         ST_DN_LOAD: begin
            hold_in = rd_a_ff;
            pos_in  = '0;
         end
         ST_DN_CMP: begin
            if (child_wins) begin
               pos_in = best_idx;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // RAM: one write port, two registered read ports
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      hold_ff    <= hold_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_top_ff     <= (count_ff == '0) ? '0 : top_ff;
         rsp_count_ff   <= COUNT_OUT_W'(count_ff);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.removed_value = rsp_removed_ff;
   assign rsp_ch.top_value     = rsp_top_ff;
   assign rsp_ch.entry_count   = rsp_count_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   assign remove_on_empty = req_accept && (req_ch.req_type == REQ_REMOVE) && (count_ff == '0);
   assign empty_flagged   = (state_ff == ST_DONE) && (status_ff == STATUS_EMPTY)
                            && (count_ff == '0);
   assign full_status_out = rsp_load && (status_ff == STATUS_FULL);
   assign queue_full      = (count_ff == CW'(CAPACITY));

   `MHPQ_ASSERT(a_count_bound, clock, reset, (count_ff <= CW'(CAPACITY)), "count overflow")
   `MHPQ_ASSERT(a_up_not_root, clock, reset, (state_ff == ST_UP_CMP |-> pos_ff != '0), "at root")
   `MHPQ_ASSERT(a_dn_child_ok, clock, reset, (state_ff == ST_DN_CMP |-> left_ok), "no child")
   `MHPQ_ASSERT(a_empty_remove, clock, reset, (remove_on_empty |=> empty_flagged), "not flagged")
   `MHPQ_ASSERT(a_full_insert, clock, reset, (full_status_out |-> queue_full), "full with room")

endmodule
